[rtl/smig_pkg.sv]
`default_nettype none

package smig_pkg;

  // Field and register widths
  localparam int CFG_W   = 9;   // slice and stack count registers, slice and band counters
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 17;  // vertex index width
  localparam int PHASE_W = 2;
  localparam int CIDX_W  = 2;   // configuration register index

  // Default bounds on the counts
  localparam int DEF_MAX_SLICES = 256;
  localparam int DEF_MAX_STACKS = 256;

  // Shape codes
  localparam logic [MODE_W-1:0] MODE_SPHERE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CYLINDER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONE     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CAPSULE  = 2'd3;

  // Walk phases
  localparam logic [PHASE_W-1:0] PH_NEAR = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BAND = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SHAPE_MODE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SLICE_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_STACK_COUNT = 2'd2;

  // Reset values of the registers
  localparam logic [MODE_W-1:0] RST_SHAPE_MODE  = MODE_SPHERE;
  localparam logic [CFG_W-1:0]  RST_SLICE_COUNT = 9'd16;
  localparam logic [CFG_W-1:0]  RST_STACK_COUNT = 9'd8;

  // First band ring of the pole-based shapes, which holds after reset
  localparam logic [IDX_W-1:0] POLE_FIRST_RING = 17'd1;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CFG_W-1:0]   band_cnt;
    logic [CFG_W-1:0]   slice_cnt;
    logic               upper_half;
    logic [IDX_W-1:0]   band_base;
  } walk_state_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_vertex;
    logic [IDX_W-1:0] second_vertex;
    logic [IDX_W-1:0] third_vertex;
    logic             last_triangle;
  } tri_word_t;

endpackage

`default_nettype wire

[rtl/smig_step.sv]
`default_nettype none

module smig_step
  import smig_pkg::*;
#(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int MAX_STACKS = DEF_MAX_STACKS
) (
  input  wire logic [MODE_W-1:0] shape_mode,
  input  wire logic [CFG_W-1:0]  slice_count,
  input  wire logic [CFG_W-1:0]  stack_count,
  input  wire logic              restart,
  input  wire walk_state_t       cur_state,
  output walk_state_t            nxt_state,
  output tri_word_t              tri_word
);

  localparam int RW      = CFG_W + 1;
  localparam int CNT_MAX = (2 ** CFG_W) - 1;
  localparam logic [CFG_W-1:0] SMAX =
    CFG_W'((MAX_SLICES < CNT_MAX) ? MAX_SLICES : CNT_MAX);
  localparam logic [CFG_W-1:0] TMAX =
    CFG_W'((MAX_STACKS < CNT_MAX) ? MAX_STACKS : CNT_MAX);
  localparam logic [CFG_W-1:0] SMIN = CFG_W'(3);
  localparam logic [CFG_W-1:0] TMIN = CFG_W'(2);

  logic [CFG_W-1:0]  s_eff;
  logic [CFG_W-1:0]  t_clamp;
  logic [RW-1:0]     s_w;
  logic [RW-1:0]     r_w;
  logic [RW-1:0]     t_eff;
  logic [RW-1:0]     nb;
  logic [RW-1:0]     pole_mult;
  logic [2*RW-1:0]   pole_prod;
  logic [IDX_W-1:0]  first_ring;
  logic [IDX_W-1:0]  r_idx;
  logic [IDX_W-1:0]  far_pole;
  logic [IDX_W-1:0]  far_base;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  slice_idx;
  logic [RW-1:0]     slice_inc;
  logic [RW-1:0]     band_inc;
  logic              sph_wind;
  walk_state_t       rewound;
  walk_state_t       st;

  // Effective counts after clamping and capsule rounding.
  always_comb begin
    s_eff = slice_count;
    if (s_eff < SMIN) s_eff = SMIN;
    if (s_eff > SMAX) s_eff = SMAX;
    t_clamp = stack_count;
    if (t_clamp < TMIN) t_clamp = TMIN;
    if (t_clamp > TMAX) t_clamp = TMAX;
    t_eff = {1'b0, t_clamp};
    if (shape_mode == MODE_CAPSULE && t_clamp[0]) t_eff = t_eff + RW'(1);
  end

  assign s_w   = {1'b0, s_eff};
  assign r_w   = s_w + RW'(1);
  assign r_idx = IDX_W'(r_w);

  always_comb begin
    case (shape_mode)
      MODE_SPHERE: begin
        nb        = t_eff - RW'(2);
        pole_mult = t_eff - RW'(1);
      end
      MODE_CYLINDER: begin
        nb        = t_eff;
        pole_mult = t_eff + RW'(3);
      end
      MODE_CONE: begin
        nb        = t_eff - RW'(1);
        pole_mult = t_eff + RW'(1);
      end
      default: begin
        nb        = t_eff - RW'(1);
        pole_mult = t_eff;
      end
    endcase
  end

  assign first_ring = (shape_mode == MODE_CYLINDER || shape_mode == MODE_CONE) ?
                      IDX_W'(s_eff) + IDX_W'(2) : POLE_FIRST_RING;
  assign sph_wind   = (shape_mode == MODE_SPHERE || shape_mode == MODE_CAPSULE);

  always_comb begin
    rewound            = '0;
    rewound.phase      = PH_NEAR;
    rewound.band_base  = first_ring;
  end

  assign st = restart ? rewound : cur_state;

  // Vertex arithmetic, all modulo the index width.
  assign pole_prod = (2*RW)'(pole_mult) * (2*RW)'(r_w);
  assign far_pole  = IDX_W'(pole_prod) + IDX_W'(1);
  assign slice_idx = IDX_W'(st.slice_cnt);
  assign far_base  = far_pole - r_idx + slice_idx;
  assign lo        = st.band_base + slice_idx;
  assign hi        = lo + r_idx;
  assign slice_inc = {1'b0, st.slice_cnt} + RW'(1);
  assign band_inc  = {1'b0, st.band_cnt} + RW'(1);

  always_comb begin
    tri_word.last_triangle = 1'b0;
    case (st.phase)
      PH_BAND: begin
        if (sph_wind) begin
          if (!st.upper_half) begin
            tri_word.first_vertex  = lo;
            tri_word.second_vertex = lo + IDX_W'(1);
            tri_word.third_vertex  = hi;
          end else begin
            tri_word.first_vertex  = hi;
            tri_word.second_vertex = lo + IDX_W'(1);
            tri_word.third_vertex  = hi + IDX_W'(1);
          end
        end else begin
          if (!st.upper_half) begin
            tri_word.first_vertex  = lo;
            tri_word.second_vertex = hi;
            tri_word.third_vertex  = hi + IDX_W'(1);
          end else begin
            tri_word.first_vertex  = lo;
            tri_word.second_vertex = hi + IDX_W'(1);
            tri_word.third_vertex  = lo + IDX_W'(1);
          end
        end
      end
      PH_FAR: begin
        tri_word.first_vertex = far_pole;
        if (shape_mode == MODE_SPHERE) begin
          tri_word.second_vertex = far_base;
          tri_word.third_vertex  = far_base + IDX_W'(1);
        end else begin
          tri_word.second_vertex = far_base + IDX_W'(1);
          tri_word.third_vertex  = far_base;
        end
        tri_word.last_triangle = (slice_inc >= s_w);
      end
      default: begin
        tri_word.first_vertex = '0;
        if (shape_mode == MODE_SPHERE) begin
          tri_word.second_vertex = slice_idx + IDX_W'(2);
          tri_word.third_vertex  = slice_idx + IDX_W'(1);
        end else begin
          tri_word.second_vertex = slice_idx + IDX_W'(1);
          tri_word.third_vertex  = slice_idx + IDX_W'(2);
        end
      end
    endcase
  end

  // Counter advance.
  always_comb begin
    nxt_state = st;
    case (st.phase)
      PH_BAND: begin
        if (!st.upper_half) begin
          nxt_state.upper_half = 1'b1;
        end else begin
          nxt_state.upper_half = 1'b0;
          nxt_state.slice_cnt  = slice_inc[CFG_W-1:0];
          if (slice_inc >= s_w) begin
            nxt_state.slice_cnt = '0;
            nxt_state.band_cnt  = band_inc[CFG_W-1:0];
            nxt_state.band_base = st.band_base + r_idx;
            if (band_inc >= nb) nxt_state.phase = PH_FAR;
          end
        end
      end
      PH_FAR: begin
        if (slice_inc >= s_w) begin
          nxt_state = rewound;
        end else begin
          nxt_state.slice_cnt = slice_inc[CFG_W-1:0];
        end
      end
      default: begin
        nxt_state.slice_cnt = slice_inc[CFG_W-1:0];
        nxt_state.phase     = PH_NEAR;
        if (slice_inc >= s_w) begin
          nxt_state.slice_cnt  = '0;
          nxt_state.band_cnt   = '0;
          nxt_state.upper_half = 1'b0;
          if (nb != '0) begin
            nxt_state.phase     = PH_BAND;
            nxt_state.band_base = first_ring;
          end else begin
            nxt_state.phase = PH_FAR;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/solid_mesh_triangle_index_generator.sv]
`default_nettype none

// Triangle index generator for ring-and-slice meshes (sphere, cylinder, cone
// and capsule). Every accepted input word produces exactly one output word
// holding the three vertex indices of the next triangle and a flag on the
// final triangle of the mesh; the word after that flag starts the mesh again,
// and an input word with in_restart set rewinds the walk before its triangle
// is produced. The walk covers the near cap fan, then the quad bands (two
// triangles per quad), then the far cap fan. Throughput is one word per
// clock cycle when not stalled: the next triangle and the next counter
// values come from a single combinational pass over the walk registers,
// and the result lands in an output register as the input word is taken.
// The input side stays ready whenever that output register is empty or is
// being drained in the same cycle, so a stalled consumer holds back at most
// one word. Slice and stack counts outside their legal ranges are clamped
// before use, and the capsule rounds an odd stack count up to the next even
// one. The configuration registers should be written only while no word is
// in flight; a change part-way through a mesh takes effect on the next word.

module solid_mesh_triangle_index_generator
  import smig_pkg::*;
#(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int MAX_STACKS = DEF_MAX_STACKS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_restart,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       out_first_vertex,
  output logic [IDX_W-1:0]       out_second_vertex,
  output logic [IDX_W-1:0]       out_third_vertex,
  output logic                   out_last_triangle
);

  logic [MODE_W-1:0] shape_mode_r;
  logic [CFG_W-1:0]  slice_count_r;
  logic [CFG_W-1:0]  stack_count_r;

  walk_state_t       state_r;
  walk_state_t       state_nxt;
  tri_word_t         tri_nxt;
  tri_word_t         tri_r;
  logic              out_valid_r;
  logic              in_accept;

  // Configuration registers. An index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r  <= RST_SHAPE_MODE;
      slice_count_r <= RST_SLICE_COUNT;
      stack_count_r <= RST_STACK_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE_MODE:  shape_mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_SLICE_COUNT: slice_count_r <= cfg_wdata;
        REG_STACK_COUNT: stack_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output register can take a new word when it is empty or is being
  // emptied in this very cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  smig_step #(
    .MAX_SLICES (MAX_SLICES),
    .MAX_STACKS (MAX_STACKS)
  ) u_step (
    .shape_mode  (shape_mode_r),
    .slice_count (slice_count_r),
    .stack_count (stack_count_r),
    .restart     (in_restart),
    .cur_state   (state_r),
    .nxt_state   (state_nxt),
    .tri_word    (tri_nxt)
  );

  // Walk state only moves when a word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_NEAR, band_cnt: '0, slice_cnt: '0, upper_half: 1'b0,
                   band_base: POLE_FIRST_RING};
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tri_r <= tri_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_vertex  = tri_r.first_vertex;
  assign out_second_vertex = tri_r.second_vertex;
  assign out_third_vertex  = tri_r.third_vertex;
  assign out_last_triangle = tri_r.last_triangle;

endmodule

`default_nettype wire
